// ===== rtl/hcs_pkg.sv =====
`timescale 1ns / 1ps

package hcs_pkg;

   localparam int PIX_BITS = 8;
   localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;
   localparam int DIV_STEPS = PIX_BITS;
   localparam int CNT_BITS = $clog2(DIV_STEPS);

   // operation codes
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_SCAN    = 2'd1;
   localparam logic [1:0] OP_STRETCH = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [PIX_BITS-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] stretched;
      logic                flat_image;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_stats;
      logic scan_stats;
      logic latch_pixel;
      logic div_start;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic flat;
   } sts_type;

endpackage

// ===== rtl/hcs_datapath.sv =====
`timescale 1ns / 1ps

module hcs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  hcs_pkg::req_type req_item,
   input  hcs_pkg::cmd_type cmd,
   output hcs_pkg::sts_type sts,
   output hcs_pkg::rsp_type rsp_item
);
   import hcs_pkg::*;

   logic [PIX_BITS-1:0] low_ff, low_in;
   logic [PIX_BITS-1:0] high_ff, high_in;
   logic [PIX_BITS-1:0] pix_ff, pix_in;
   logic [PIX_BITS-1:0] divisor_ff, divisor_in;
   logic [PIX_BITS-1:0] rem_ff, rem_in;
   logic [PIX_BITS-1:0] dvd_ff, dvd_in;
   logic [PIX_BITS-1:0] quot_ff, quot_in;
   rsp_type             rsp_ff, rsp_in;

   logic [PIX_BITS:0]     rem_shift;
   logic                  quot_bit;
   logic [PIX_BITS-1:0]   diff;
   logic [2*PIX_BITS-1:0] product;

   assign sts.flat = (high_ff <= low_ff);
   assign rsp_item = rsp_ff;

   // one restoring divide step per cycle
   assign rem_shift = {rem_ff, dvd_ff[PIX_BITS-1]};
   assign quot_bit  = (rem_shift >= {1'b0, divisor_ff});

   assign diff    = pix_ff - low_ff;
   assign product = {{PIX_BITS{1'b0}}, diff} * {{PIX_BITS{1'b0}}, quot_ff};

   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      pix_in     = pix_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      quot_in    = quot_ff;
      rsp_in     = rsp_ff;

      if (cmd.clear_stats) begin
         low_in  = PIX_MAX;
         high_in = '0;
      end
      if (cmd.scan_stats) begin
         if (req_item.pixel < low_ff) begin
            low_in = req_item.pixel;
         end
         if (req_item.pixel > high_ff) begin
            high_in = req_item.pixel;
         end
      end
      if (cmd.latch_pixel) begin
         pix_in = req_item.pixel;
      end
      if (cmd.div_start) begin
         divisor_in = high_ff - low_ff;
         rem_in     = '0;
         dvd_in     = PIX_MAX;
         quot_in    = '0;
      end
      if (cmd.div_step) begin
         rem_in  = quot_bit ? PIX_BITS'(rem_shift - {1'b0, divisor_ff})
                            : rem_shift[PIX_BITS-1:0];
         dvd_in  = {dvd_ff[PIX_BITS-2:0], 1'b0};
         quot_in = {quot_ff[PIX_BITS-2:0], quot_bit};
      end
      if (cmd.rsp_load) begin
         rsp_in.flat_image = sts.flat;
         if (sts.flat || (pix_ff <= low_ff)) begin
            rsp_in.stretched = '0;
         end else if (product > {{PIX_BITS{1'b0}}, PIX_MAX}) begin
            rsp_in.stretched = PIX_MAX;
         end else begin
            rsp_in.stretched = product[PIX_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= PIX_MAX;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quot_ff    <= quot_in;
      rsp_ff     <= rsp_in;
   end

   a_scan_low: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_stats |=> (low_ff <= $past(req_item.pixel)))
      else $error("darkest value above scanned pixel");

   a_scan_high: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_stats |=> (high_ff >= $past(req_item.pixel)))
      else $error("brightest value below scanned pixel");

   a_clear_stats: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_stats |=> (low_ff == PIX_MAX && high_ff == '0))
      else $error("statistics not restored by clear");

endmodule

// ===== rtl/hcs_ctrl.sv =====
`timescale 1ns / 1ps

module hcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hcs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  hcs_pkg::sts_type sts,
   output hcs_pkg::cmd_type cmd
);
   import hcs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                factor_ok_ff, factor_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      factor_ok_in = factor_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.operation)
                  OP_CLEAR: begin
                     cmd.clear_stats = 1'b1;
                     factor_ok_in    = 1'b0;
                  end
                  OP_SCAN: begin
                     cmd.scan_stats = 1'b1;
                     factor_ok_in   = 1'b0;
                  end
                  OP_STRETCH: begin
                     cmd.latch_pixel = 1'b1;
                     if (factor_ok_ff || sts.flat) begin
                        state_in = ST_MUL;
                     end else begin
                        cmd.div_start = 1'b1;
                        cnt_in        = '0;
                        state_in      = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               factor_ok_in = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         factor_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         factor_ok_ff <= factor_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MUL))
      else $error("result raised outside multiply state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_BITS'(DIV_STEPS - 1)) |=>
         (state_ff == ST_MUL && factor_ok_ff))
      else $error("divide did not finish after last step");

   a_scan_drops_factor: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_stats || cmd.clear_stats) |=> !factor_ok_ff)
      else $error("cached factor survived a statistics change");

endmodule

// ===== rtl/histogram_contrast_stretch.sv =====
`timescale 1ns / 1ps

// Min/max contrast stretch for 8-bit gray pixels in two passes. A clear resets the
// darkest/brightest statistics, a scan folds a pixel into them, and a stretch returns
// (pixel - darkest) * floor(255 / (brightest - darkest)) clamped to 0..255, or 0 with
// flat_image set when brightest <= darkest. Clear and scan give no result. Items are
// handled one at a time: the first stretch after the statistics change runs a
// restoring divider for the factor unless the statistics are flat; later stretches
// reuse the cached factor. The result sits in an output register, so clears and scans
// are still taken while a result waits to transfer.
module histogram_contrast_stretch (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hcs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hcs_pkg::rsp_type rsp_item
);
   import hcs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing: accept, divide steps, result load
   hcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // statistics, divider, multiply/clamp and result register
   hcs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule
